// ----- rtl/green_pixel_classifier_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the green pixel classifier
// Clocked implication checks, reset-qualified, reported by $error.
// ----------------------------------------------------------------------------
`ifndef GREEN_PIXEL_CLASSIFIER_ASSERT_SVH
`define GREEN_PIXEL_CLASSIFIER_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define GPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gpc check failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gpc check failed: next-cycle implication");

`endif

// ----- rtl/gpc_pkg.sv -----
// ----------------------------------------------------------------------------
// gpc_pkg
// Widths and constants shared by the green pixel classifier.
// ----------------------------------------------------------------------------
package gpc_pkg;

	localparam int PIX_W    = 8;   // one color channel
	localparam int RATE_W   = 10;  // ratio_rate register
	localparam int SUM_W    = 10;  // blue + green + red, at most 765
	localparam int DEN_W    = 9;   // blue + 1 or blue + 2, at most 257
	localparam int SCALED_W = 20;  // sum * rate, at most 782595
	localparam int FS_W     = 20;  // width of the full-scale constant
	localparam int PROD_W   = 28;  // cross products, below 2^28

	localparam logic [PIX_W-1:0]  MARGIN     = 8'd10;
	localparam logic [FS_W-1:0]   FULL_SCALE = 20'd765000;
	localparam logic [RATE_W-1:0] RATE_RESET = 10'd1000;

	typedef logic [PIX_W-1:0]    pix_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [DEN_W-1:0]    den_t;
	typedef logic [SCALED_W-1:0] scaled_t;
	typedef logic [PROD_W-1:0]   prod_t;

endpackage

// ----- rtl/green_pixel_classifier.sv -----
// ----------------------------------------------------------------------------
// green_pixel_classifier
// Classifies BGR pixels as green or not, one per clock unless stalled, zeroing non-green pixels.
// ----------------------------------------------------------------------------
// A pixel is green when red and blue each sit more than 10 below green and
// both (green - blue) / (blue + 1) and (green - red) / (blue + 2) exceed
// (blue + green + red) * ratio_rate / 765000. The ratios are compared exactly
// by cross-multiplication, so there is no rounding anywhere. A green pixel
// leaves unchanged with is_green set; any other pixel leaves as all zeros.
// The block takes one pixel word per clock while the output is not stalled
// and returns one result word per pixel, in order. Each pixel passes four
// register stages (margin test and sum, first multiplies, second multiplies,
// final compare into the output register) before res_valid rises for it.
// Holding res_ready low while res_valid is set freezes the whole pipeline
// and drops pix_ready in the same cycle; nothing is lost or repeated. Write
// ratio_rate only while no pixel is in flight.
// ----------------------------------------------------------------------------
module green_pixel_classifier (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      ratio_rate_we,
	input  logic [gpc_pkg::RATE_W-1:0] ratio_rate_wdata,
	// pixel channel
	input  logic                      pix_valid,
	output logic                      pix_ready,
	input  logic [gpc_pkg::PIX_W-1:0] blue,
	input  logic [gpc_pkg::PIX_W-1:0] green,
	input  logic [gpc_pkg::PIX_W-1:0] red,
	// result channel
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [gpc_pkg::PIX_W-1:0] blue_out,
	output logic [gpc_pkg::PIX_W-1:0] green_out,
	output logic [gpc_pkg::PIX_W-1:0] red_out,
	output logic                      is_green
);

`include "green_pixel_classifier_assert.svh"

	// Threshold scale register
	logic [gpc_pkg::RATE_W-1:0] ratio_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_rate_q <= gpc_pkg::RATE_RESET;
		end else if (ratio_rate_we) begin
			ratio_rate_q <= ratio_rate_wdata;
		end
	end

	// The pipeline moves as one: every stage advances unless the output word
	// is held by a stalled consumer.
	logic advance;
	assign advance   = !res_valid || res_ready;
	assign pix_ready = advance;

	// Stage 1: register pixel, margin tests, differences, sum, denominators
	logic            valid_s1;
	gpc_pkg::pix_t   blue_s1, green_s1, red_s1;
	logic            margin_ok_s1;
	gpc_pkg::pix_t   diff_gb_s1, diff_gr_s1;
	gpc_pkg::sum_t   sum_s1;
	gpc_pkg::den_t   den1_s1, den2_s1;

	logic margin_ok;
	assign margin_ok =
		(({1'b0, red}  + {1'b0, gpc_pkg::MARGIN}) < {1'b0, green}) &&
		(({1'b0, blue} + {1'b0, gpc_pkg::MARGIN}) < {1'b0, green});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			blue_s1      <= blue;
			green_s1     <= green;
			red_s1       <= red;
			margin_ok_s1 <= margin_ok;
			// Can wrap only when the margin fails; the result is then discarded.
			diff_gb_s1   <= green - blue;
			diff_gr_s1   <= green - red;
			sum_s1       <= {2'b00, blue} + {2'b00, green} + {2'b00, red};
			den1_s1      <= {1'b0, blue} + 9'd1;
			den2_s1      <= {1'b0, blue} + 9'd2;
		end
	end

	// Stage 2: scale the sum, scale the differences to full range
	logic              valid_s2;
	gpc_pkg::pix_t     blue_s2, green_s2, red_s2;
	logic              margin_ok_s2;
	gpc_pkg::scaled_t  scaled_s2;
	gpc_pkg::prod_t    lhs1_s2, lhs2_s2;
	gpc_pkg::den_t     den1_s2, den2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			blue_s2      <= blue_s1;
			green_s2     <= green_s1;
			red_s2       <= red_s1;
			margin_ok_s2 <= margin_ok_s1;
			scaled_s2    <= {10'd0, sum_s1} * {10'd0, ratio_rate_q};
			lhs1_s2      <= {20'd0, diff_gb_s1} * {8'd0, gpc_pkg::FULL_SCALE};
			lhs2_s2      <= {20'd0, diff_gr_s1} * {8'd0, gpc_pkg::FULL_SCALE};
			den1_s2      <= den1_s1;
			den2_s2      <= den2_s1;
		end
	end

	// Stage 3: threshold side of both cross-multiplications
	logic            valid_s3;
	gpc_pkg::pix_t   blue_s3, green_s3, red_s3;
	logic            margin_ok_s3;
	gpc_pkg::prod_t  lhs1_s3, lhs2_s3, rhs1_s3, rhs2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			blue_s3      <= blue_s2;
			green_s3     <= green_s2;
			red_s3       <= red_s2;
			margin_ok_s3 <= margin_ok_s2;
			lhs1_s3      <= lhs1_s2;
			lhs2_s3      <= lhs2_s2;
			rhs1_s3      <= {8'd0, scaled_s2} * {19'd0, den1_s2};
			rhs2_s3      <= {8'd0, scaled_s2} * {19'd0, den2_s2};
		end
	end

	// Stage 4: compare and drive the output register
	logic green_hit;
	assign green_hit = margin_ok_s3 && (lhs1_s3 > rhs1_s3) && (lhs2_s3 > rhs2_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			is_green  <= green_hit;
			blue_out  <= green_hit ? blue_s3  : '0;
			green_out <= green_hit ? green_s3 : '0;
			red_out   <= green_hit ? red_s3   : '0;
		end
	end

	// Checks
	logic out_zero;
	logic out_margin_ok;
	assign out_zero      = ({blue_out, green_out, red_out} == '0);
	assign out_margin_ok =
		(({1'b0, red_out}  + {1'b0, gpc_pkg::MARGIN}) < {1'b0, green_out}) &&
		(({1'b0, blue_out} + {1'b0, gpc_pkg::MARGIN}) < {1'b0, green_out});

	`GPC_ASSERT_SAME(a_reject_zeroed, clk, arst_n, res_valid && !is_green, out_zero)
	`GPC_ASSERT_SAME(a_green_margin, clk, arst_n, res_valid && is_green, out_margin_ok)
	`GPC_ASSERT_NEXT(a_accept_enters, clk, arst_n, pix_valid && pix_ready, valid_s1)
	`GPC_ASSERT_NEXT(a_stall_holds, clk, arst_n, valid_s3 && !advance, valid_s3 && $stable(rhs1_s3))

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for green_pixel_classifier
// Feeds BGR pixel words through random handshake gaps and checks every
// result word. A local model predicts the green decision by exact
// cross-multiplication. The run covers several ratio_rate settings,
// including 0 and values above 1000, and one long output stall that
// backs the pipeline up into the pixel input.
// ----------------------------------------------------------------------------
module tb_top;

	typedef logic [gpc_pkg::RATE_W-1:0] rate_t;

	// One result word: the pixel as it leaves, plus the decision flag.
	typedef struct packed {
		gpc_pkg::pix_t b;
		gpc_pkg::pix_t g;
		gpc_pkg::pix_t r;
		logic          flag;
	} pix_word_t;

	// Keeps the expected result words in order and compares each returned
	// word with the oldest one. Holds its own copy of ratio_rate.
	class green_scoreboard;
		rate_t             rate;
		pix_word_t         expected_q[$];
		int                errors;

		function new();
			rate   = gpc_pkg::RATE_RESET;
			errors = 0;
		endfunction

		function void set_rate(rate_t value);
			rate = value;
		endfunction

		// Exact green test: margins first, then both ratios against the
		// scaled brightness, cross-multiplied so nothing rounds.
		function pix_word_t classify(gpc_pkg::pix_t b, gpc_pkg::pix_t g, gpc_pkg::pix_t r);
			gpc_pkg::sum_t    s;
			gpc_pkg::scaled_t scaled;
			gpc_pkg::den_t    den_b1;
			gpc_pkg::den_t    den_b2;
			gpc_pkg::prod_t   lhs_gb;
			gpc_pkg::prod_t   lhs_gr;
			gpc_pkg::prod_t   rhs_gb;
			gpc_pkg::prod_t   rhs_gr;
			logic             keep;
			pix_word_t        res;
			s      = gpc_pkg::sum_t'(b) + gpc_pkg::sum_t'(g) + gpc_pkg::sum_t'(r);
			scaled = gpc_pkg::scaled_t'(s) * gpc_pkg::scaled_t'(rate);
			den_b1 = gpc_pkg::den_t'(b) + gpc_pkg::den_t'(1);
			den_b2 = gpc_pkg::den_t'(b) + gpc_pkg::den_t'(2);
			keep   = 1'b0;
			if (gpc_pkg::sum_t'(r) + gpc_pkg::sum_t'(gpc_pkg::MARGIN) < gpc_pkg::sum_t'(g) &&
			    gpc_pkg::sum_t'(b) + gpc_pkg::sum_t'(gpc_pkg::MARGIN) < gpc_pkg::sum_t'(g)) begin
				lhs_gb = gpc_pkg::prod_t'(g - b) * gpc_pkg::prod_t'(gpc_pkg::FULL_SCALE);
				lhs_gr = gpc_pkg::prod_t'(g - r) * gpc_pkg::prod_t'(gpc_pkg::FULL_SCALE);
				rhs_gb = gpc_pkg::prod_t'(scaled) * gpc_pkg::prod_t'(den_b1);
				rhs_gr = gpc_pkg::prod_t'(scaled) * gpc_pkg::prod_t'(den_b2);
				keep   = (lhs_gb > rhs_gb) && (lhs_gr > rhs_gr);
			end
			res.b    = keep ? b : '0;
			res.g    = keep ? g : '0;
			res.r    = keep ? r : '0;
			res.flag = keep;
			return res;
		endfunction

		function void note_pixel(gpc_pkg::pix_t b, gpc_pkg::pix_t g, gpc_pkg::pix_t r);
			expected_q = {expected_q, classify(b, g, r)};
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			$display("mismatch at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_result(pix_word_t got);
			pix_word_t want;
			if (expected_q.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				want = expected_q.pop_front();
				if (got.b !== want.b)
					report($sformatf("blue_out %0d, expected %0d", got.b, want.b));
				if (got.g !== want.g)
					report($sformatf("green_out %0d, expected %0d", got.g, want.g));
				if (got.r !== want.r)
					report($sformatf("red_out %0d, expected %0d", got.r, want.r));
				if (got.flag !== want.flag)
					report($sformatf("is_green %0b, expected %0b", got.flag, want.flag));
			end
		endtask
	endclass

	localparam int PHASES        = 7;
	localparam int PHASE_ITEMS   = 115;
	localparam int SQUEEZE_PHASE = 2;    // phase with the long output stall
	localparam int SQUEEZE_HOLD  = 120;  // cycles res_ready stays low there
	localparam int SETTLE_CYCLES = 8;    // pipeline is four deep; allow margin

	logic                 clk;
	logic                 arst_n           = 1'b0;
	logic                 ratio_rate_we    = 1'b0;
	rate_t                ratio_rate_wdata = '0;
	logic                 pix_valid        = 1'b0;
	logic                 pix_ready;
	gpc_pkg::pix_t        blue             = '0;
	gpc_pkg::pix_t        green            = '0;
	gpc_pkg::pix_t        red              = '0;
	logic                 res_valid;
	logic                 res_ready        = 1'b0;
	gpc_pkg::pix_t        blue_out;
	gpc_pkg::pix_t        green_out;
	gpc_pkg::pix_t        red_out;
	logic                 is_green;

	green_scoreboard pixel_sb = new();
	int              hold_len = 0;  // set by the stimulus, acted on once by the receiver

	green_pixel_classifier u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.ratio_rate_we    (ratio_rate_we),
		.ratio_rate_wdata (ratio_rate_wdata),
		.pix_valid        (pix_valid),
		.pix_ready        (pix_ready),
		.blue             (blue),
		.green            (green),
		.red              (red),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.blue_out         (blue_out),
		.green_out        (green_out),
		.red_out          (red_out),
		.is_green         (is_green)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one pixel word. Valid stays high from the previous word when
	// there is no gap, so it is never dropped and raised in the same step.
	task automatic send_pixel(input gpc_pkg::pix_t b, input gpc_pkg::pix_t g,
		input gpc_pkg::pix_t r, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		blue      <= b;
		green     <= g;
		red       <= r;
		do @(posedge clk); while (!pix_ready);
		pixel_sb.note_pixel(b, g, r);
	endtask

	// Drop valid after the last word of a burst so nothing is taken twice.
	task automatic end_burst();
		@(negedge clk);
		pix_valid <= 1'b0;
	endtask

	// Wait until every expected word is back, then let the pipeline settle.
	task automatic drain();
		int spent;
		spent = 0;
		while (pixel_sb.pending() > 0 && spent < 20000) begin
			@(posedge clk);
			spent++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write ratio_rate; the caller makes sure the pipeline is empty.
	task automatic write_rate(input rate_t value);
		@(negedge clk);
		ratio_rate_we    <= 1'b1;
		ratio_rate_wdata <= value;
		@(negedge clk);
		ratio_rate_we    <= 1'b0;
		pixel_sb.set_rate(value);
	endtask

	// Draw a pixel. Most are green candidates (green clears the margin over a
	// mostly small blue and over red), some sit right on the margin, the rest are noise.
	task automatic pick_pixel(output gpc_pkg::pix_t b, output gpc_pkg::pix_t g,
		output gpc_pkg::pix_t r);
		int kind;
		int top;
		kind = int'($urandom_range(0, 9));
		if (kind < 6) begin
			g   = gpc_pkg::pix_t'($urandom_range(11, 255));
			top = (g < 51 || $urandom_range(0, 3) == 0) ?
				int'(g) - 11 : int'($urandom_range(0, 40));
			b   = gpc_pkg::pix_t'($urandom_range(0, top));
			r   = gpc_pkg::pix_t'($urandom_range(0, int'(g) - 11));
		end else if (kind < 8) begin
			g = gpc_pkg::pix_t'($urandom_range(11, 255));
			b = $urandom_range(0, 1) ?
				gpc_pkg::pix_t'(int'(g) - int'($urandom_range(10, 11))) :
				gpc_pkg::pix_t'($urandom_range(0, int'(g) - 11));
			r = $urandom_range(0, 1) ?
				gpc_pkg::pix_t'(int'(g) - int'($urandom_range(10, 11))) :
				gpc_pkg::pix_t'($urandom_range(0, int'(g) - 11));
		end else begin
			b = gpc_pkg::pix_t'($urandom_range(0, 255));
			g = gpc_pkg::pix_t'($urandom_range(0, 255));
			r = gpc_pkg::pix_t'($urandom_range(0, 255));
		end
	endtask

	// Edge pixels: all zero, all ones, margin just met and just missed on
	// each side, both ratios near their thresholds, alternating bit patterns.
	task automatic run_directed();
		send_pixel(8'd0,   8'd0,   8'd0,   0);
		send_pixel(8'd255, 8'd255, 8'd255, 0);
		send_pixel(8'd0,   8'd255, 8'd0,   0);
		send_pixel(8'd0,   8'd11,  8'd0,   1);
		send_pixel(8'd0,   8'd10,  8'd0,   0);
		send_pixel(8'd1,   8'd12,  8'd0,   0);
		send_pixel(8'd0,   8'd255, 8'd245, 2);
		send_pixel(8'd0,   8'd255, 8'd244, 0);
		send_pixel(8'd245, 8'd255, 8'd0,   0);
		send_pixel(8'd244, 8'd255, 8'd0,   0);
		send_pixel(8'd100, 8'd255, 8'd0,   3);
		send_pixel(8'd160, 8'd255, 8'd0,   0);
		send_pixel(8'd165, 8'd255, 8'd0,   0);
		send_pixel(8'd150, 8'd255, 8'd100, 0);
		send_pixel(8'd120, 8'd255, 8'd200, 0);
		send_pixel(8'd40,  8'd255, 8'd230, 1);
		send_pixel(8'hAA,  8'h55,  8'hAA,  0);
		send_pixel(8'h55,  8'hAA,  8'h55,  0);
		send_pixel(8'd255, 8'd0,   8'd255, 0);
		send_pixel(8'd0,   8'd128, 8'd117, 0);
	endtask

	// Stimulus: one burst per ratio_rate setting, with the directed edge
	// pixels in the first one.
	initial begin
		rate_t             rates[PHASES];
		gpc_pkg::pix_t     b;
		gpc_pkg::pix_t     g;
		gpc_pkg::pix_t     r;
		bit                gappy;
		int                gap;
		rates[0] = gpc_pkg::RATE_RESET;
		rates[1] = '0;
		rates[2] = 10'd1023;
		rates[3] = 10'd1;
		rates[4] = rate_t'($urandom_range(1001, 1023));
		rates[5] = rate_t'($urandom_range(2, 999));
		rates[6] = 10'd765;
		gappy    = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			write_rate(rates[p]);
			if (p == 0)
				run_directed();
			if (p == SQUEEZE_PHASE)
				hold_len = SQUEEZE_HOLD;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 32 == 0)
					gappy = ($urandom_range(0, 1) != 0);
				gap = (gappy && p != SQUEEZE_PHASE) ? int'($urandom_range(0, 15)) : 0;
				pick_pixel(b, g, r);
				send_pixel(b, g, r, gap);
			end
			end_burst();
			drain();
		end

		if (pixel_sb.pending() > 0)
			pixel_sb.report($sformatf("%0d result words never arrived", pixel_sb.pending()));
		if (pixel_sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Receiver: draw a stall before each word, or hold off for a long
	// stretch once when asked, then take the word and check it.
	initial begin
		pix_word_t got;
		int        wait_n;
		int        served;
		bit        gappy;
		bit        held;
		served = 0;
		gappy  = 1'b0;
		held   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (served % 32 == 0)
				gappy = ($urandom_range(0, 1) != 0);
			if (hold_len > 0 && !held) begin
				wait_n = hold_len;
				held   = 1'b1;
			end else begin
				wait_n = gappy ? int'($urandom_range(0, 15)) : 0;
			end
			if (wait_n > 0) begin
				res_ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			got.b    = blue_out;
			got.g    = green_out;
			got.r    = red_out;
			got.flag = is_green;
			pixel_sb.check_result(got);
			served++;
		end
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gpc_pkg.sv
rtl/green_pixel_classifier.sv
dv/tb_top.sv
